>>> hdl/assert_macros.svh
// Assertion macros shared by the source line normaliser RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SLN_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SLN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/slnorm_pkg.sv
// Package for the source line normaliser: character codes, queue depth
// default and the command record passed from the front end to the back end.
package slnorm_pkg;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam int FIFO_DEPTH_DEF = 4;

  // One command produces one result, or two when a held space goes first.
  typedef struct packed {
    logic       sp;
    logic [7:0] ch;
    logic       line_end;
    logic       line_ok;
  } cmd_t;

endpackage

>>> hdl/slnorm_front.sv
// Front end of the source line normaliser: takes source bytes, tracks the
// scan mode and issues commands. Depends on slnorm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slnorm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_end_line,
  output logic               push,
  output slnorm_pkg::cmd_t   push_cmd,
  input  logic               push_ready
);
  import slnorm_pkg::*;

  typedef enum logic [1:0] {
    MODE_LEAD,
    MODE_TEXT,
    MODE_QUOTE,
    MODE_COMMENT
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  qk_r, qk_nxt;
  logic  sp_pend_r, sp_pend_nxt;
  logic  has_res;
  logic  accept;
  logic [7:0] close_q;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_res;
  assign close_q  = qk_r ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    mode_nxt    = mode_r;
    qk_nxt      = qk_r;
    sp_pend_nxt = sp_pend_r;
    has_res     = 1'b0;
    push_cmd    = '{sp: 1'b0, ch: in_ch, line_end: 1'b0, line_ok: 1'b0};
    if (in_end_line) begin
      has_res     = 1'b1;
      push_cmd    = '{sp: 1'b0, ch: CH_NUL, line_end: 1'b1,
                      line_ok: (mode_r != MODE_QUOTE)};
      mode_nxt    = MODE_LEAD;
      qk_nxt      = 1'b0;
      sp_pend_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_QUOTE: begin
          has_res = 1'b1;
          if (in_ch == close_q) mode_nxt = MODE_TEXT;
        end
        MODE_COMMENT: begin
        end
        default: begin
          if (in_ch <= CH_SPACE) begin
            if (mode_r == MODE_TEXT) sp_pend_nxt = 1'b1;
          end else if (in_ch == CH_SEMI) begin
            mode_nxt    = MODE_COMMENT;
            sp_pend_nxt = 1'b0;
          end else begin
            has_res     = 1'b1;
            push_cmd.sp = sp_pend_r;
            sp_pend_nxt = 1'b0;
            if (in_ch == CH_SQUOTE || in_ch == CH_DQUOTE) begin
              qk_nxt   = (in_ch == CH_DQUOTE);
              mode_nxt = MODE_QUOTE;
            end else begin
              mode_nxt = MODE_TEXT;
              if (in_ch >= CH_LOWER_A && in_ch <= CH_LOWER_Z)
                push_cmd.ch = in_ch - CASE_DIFF;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LEAD;
      qk_r      <= 1'b0;
      sp_pend_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      qk_r      <= qk_nxt;
      sp_pend_r <= sp_pend_nxt;
    end
  end

  // Inside a comment only the end of the line may produce a command.
  `SLN_ASSERT_IMP(a_comment_silent, accept && mode_r == MODE_COMMENT && !in_end_line, !push, "command issued inside comment")
  // A held space can never be carried into a quoted string.
  `SLN_ASSERT_IMP(a_quote_no_space, mode_r == MODE_QUOTE, !sp_pend_r, "space held in quote mode")

endmodule

>>> hdl/slnorm_fifo.sv
// Short command queue between the front and back ends of the source line
// normaliser. Depends on slnorm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slnorm_fifo #(
  parameter int DEPTH = slnorm_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slnorm_pkg::cmd_t   push_cmd,
  output logic               push_ready,
  input  logic               pop,
  output slnorm_pkg::cmd_t   pop_cmd,
  output logic               pop_valid
);
  import slnorm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  `SLN_ASSERT_IMP(a_no_overflow, push, push_ready, "push into full queue")
  `SLN_ASSERT_IMP(a_no_underflow, pop, pop_valid, "pop from empty queue")
  `SLN_ASSERT(a_cnt_range, cnt_r <= CW'(DEPTH), "queue count out of range")

endmodule

>>> hdl/slnorm_back.sv
// Back end of the source line normaliser: expands queued commands into
// results through an output register. Depends on slnorm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slnorm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slnorm_pkg::cmd_t   pop_cmd,
  input  logic               pop_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_line_end,
  output logic               out_line_ok
);
  import slnorm_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_end_r;
  logic       out_ok_r;
  logic       pend_r;
  logic [7:0] pend_ch_r;
  logic       out_free;

  assign out_free     = !out_valid_r || out_ready;
  assign pop          = out_free && !pend_r && pop_valid;
  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_line_end = out_end_r;
  assign out_line_ok  = out_ok_r;

  // Control state: valid and the held-byte flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= pop_valid;
        pend_r      <= pop_valid && pop_cmd.sp;
      end
    end
  end

  // Payload registers. When a space leads, the byte waits in pend_ch_r.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_r) begin
        out_char_r <= pend_ch_r;
        out_end_r  <= 1'b0;
        out_ok_r   <= 1'b0;
      end else if (pop_valid) begin
        pend_ch_r  <= pop_cmd.ch;
        out_char_r <= pop_cmd.sp ? CH_SPACE : pop_cmd.ch;
        out_end_r  <= pop_cmd.sp ? 1'b0 : pop_cmd.line_end;
        out_ok_r   <= pop_cmd.sp ? 1'b0 : pop_cmd.line_ok;
      end
    end
  end

  `SLN_ASSERT_IMP(a_pend_has_out, pend_r, out_valid_r, "held byte without a result shown")
  `SLN_ASSERT_IMP(a_space_no_end, out_valid_r && pend_r, !out_end_r, "terminator before held byte")

endmodule

>>> hdl/source_line_normalizer.sv
// Top level of the source line normaliser: front end, command queue and
// back end. Depends on slnorm_pkg, slnorm_front, slnorm_fifo and slnorm_back.
//
//   Channel | Handshake             | Fields
//   --------+-----------------------+-------------------------------------
//   in      | in_valid / in_ready   | in_ch, in_end_line
//   out     | out_valid / out_ready | out_char, out_line_end, out_line_ok
//
// One input request is taken per cycle while the command queue has room.
// Each result occupies the output register until it is taken, so a byte
// that follows a collapsed space yields two results, a space and then the
// byte; the queue of FIFO_DEPTH commands covers short bursts of these, and
// a longer run fills the queue and holds off the input. A result passes
// through the command queue and the output register before it is shown.
// Synchronous reset returns the scan to leading whitespace mode and empties
// the queue; stalls on either side hold state.
module source_line_normalizer #(
  parameter int FIFO_DEPTH = slnorm_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_line_end,
  output logic       out_line_ok
);
  import slnorm_pkg::*;

  logic push, push_ready, pop, pop_valid;
  cmd_t push_cmd, pop_cmd;

  slnorm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_end_line(in_end_line),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  slnorm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  slnorm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_cmd     (pop_cmd),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_line_end(out_line_end),
    .out_line_ok (out_line_ok)
  );

endmodule
